// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file sfc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk, disabled while rst_n is low.
`define SFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge of clk, reset included.
`define SFC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/sfc_pkg.sv =====
`default_nettype none

package sfc_pkg;

    // Geometry of the test
    localparam int NUM_PLANES           = 6;
    localparam int COORD_WIDTH          = 16;
    localparam int NORMAL_FRACTION_BITS = 14;
    localparam int NUM_SPHERES          = 2;

    // Plane register layout: nx, ny, nz, w, each PF bits
    localparam int PF            = 16;
    localparam int PLANE_W       = 4 * PF;
    localparam int RADIUS_W      = COORD_WIDTH - 1;
    localparam int CFG_IDX_W     = $clog2(NUM_PLANES + 1);

    // Exact datapath widths
    localparam int PROD_W        = PF + COORD_WIDTH;
    localparam int DIFF_W        = ((PF > COORD_WIDTH) ? PF : COORD_WIDTH) + 1;
    localparam int OFS_SH_W      = DIFF_W + NORMAL_FRACTION_BITS;
    localparam int SUM_W         = ((PROD_W > OFS_SH_W) ? PROD_W : OFS_SH_W) + 2;

    typedef logic [NUM_PLANES-1:0][PLANE_W-1:0] plane_array_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] cz;
        logic        [RADIUS_W-1:0]    r;
    } sphere_t;

    // Stage load enables handed to every lane
    typedef struct packed {
        logic s1_en;
        logic s2_en;
    } pipe_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/sphere_frustum_cull_unit.sv =====
// A pair goes through the stage 1, stage 2 and output registers. Throughput: one sphere
// pair per cycle unless stalled; each sphere has one multiply/compare lane per plane.
// A stalled result holds in the output register; empty stages still fill behind it.
// Reset (rst_n low, asynchronous) empties the pipeline and clears all planes to zero,
// which makes every sphere visible until planes are written.
`default_nettype none

module sphere_frustum_cull_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sfc_pkg::PLANE_W-1:0]      cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [sfc_pkg::COORD_WIDTH-1:0] a_center_x,
    input  wire logic signed [sfc_pkg::COORD_WIDTH-1:0] a_center_y,
    input  wire logic signed [sfc_pkg::COORD_WIDTH-1:0] a_center_z,
    input  wire logic [sfc_pkg::RADIUS_W-1:0]     a_radius,
    input  wire logic signed [sfc_pkg::COORD_WIDTH-1:0] b_center_x,
    input  wire logic signed [sfc_pkg::COORD_WIDTH-1:0] b_center_y,
    input  wire logic signed [sfc_pkg::COORD_WIDTH-1:0] b_center_z,
    input  wire logic [sfc_pkg::RADIUS_W-1:0]     b_radius,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  a_visible,
    output logic                                  b_visible
);
    import sfc_pkg::*;

    plane_array_t                                planes;
    sphere_t [NUM_SPHERES-1:0]                   spheres;
    logic    [NUM_SPHERES-1:0][NUM_PLANES-1:0]   over;
    pipe_ctl_t                                   ctl;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic out_valid_reg, out_valid_next;
    logic a_vis_reg, a_vis_next;
    logic b_vis_reg, b_vis_next;
    logic rdy1, rdy2, rdy3;

    sfc_plane_regs u_planes (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    // Gather the two spheres of a transaction
    always_comb
    begin
        spheres[0].cx = a_center_x;
        spheres[0].cy = a_center_y;
        spheres[0].cz = a_center_z;
        spheres[0].r  = a_radius;
        spheres[1].cx = b_center_x;
        spheres[1].cy = b_center_y;
        spheres[1].cz = b_center_z;
        spheres[1].r  = b_radius;
    end

    // Advance a stage when the one after it is empty or moving
    always_comb
    begin
        rdy3      = !out_valid_reg || !out_stall;
        rdy2      = !v2_reg || rdy3;
        rdy1      = !v1_reg || rdy2;
        ctl.s1_en = rdy1;
        ctl.s2_en = rdy2;
    end

    assign in_stall = !rdy1;

    // One lane per sphere and plane
    for (genvar s = 0; s < NUM_SPHERES; s++)
    begin : g_sphere
        for (genvar p = 0; p < NUM_PLANES; p++)
        begin : g_plane
            sfc_lane u_lane (
                .clk    (clk),
                .ctl    (ctl),
                .sphere (spheres[s]),
                .plane  (planes[p]),
                .over   (over[s][p])
            );
        end
    end

    // Merge: visible when no plane reports the sphere outside
    always_comb
    begin
        v1_next        = rdy1 ? in_valid : v1_reg;
        v2_next        = rdy2 ? v1_reg : v2_reg;
        out_valid_next = rdy3 ? v2_reg : out_valid_reg;
        a_vis_next     = rdy3 ? !(|over[0]) : a_vis_reg;
        b_vis_next     = rdy3 ? !(|over[1]) : b_vis_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_vis_reg <= a_vis_next;
        b_vis_reg <= b_vis_next;
    end

    assign out_valid = out_valid_reg;
    assign a_visible = a_vis_reg;
    assign b_visible = b_vis_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sfc_plane_regs.sv =====
`default_nettype none

module sfc_plane_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sfc_pkg::PLANE_W-1:0]   cfg_data,
    output sfc_pkg::plane_array_t              planes
);
    import sfc_pkg::*;

    plane_array_t planes_reg;
    plane_array_t planes_next;

    assign cfg_ready = 1'b1;
    assign planes    = planes_reg;

    // Decode the write; drop indexes past the last plane
    always_comb
    begin
        planes_next = planes_reg;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            if (cfg_valid && (cfg_index == CFG_IDX_W'(p)))
            begin
                planes_next[p] = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            planes_reg <= '0;
        end
        else
        begin
            planes_reg <= planes_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sfc_lane.sv =====
`default_nettype none

// One sphere against one plane: flags distance strictly above radius.
module sfc_lane (
    input  wire logic                        clk,
    input  wire sfc_pkg::pipe_ctl_t          ctl,
    input  wire sfc_pkg::sphere_t            sphere,
    input  wire logic [sfc_pkg::PLANE_W-1:0] plane,
    output logic                             over
);
    import sfc_pkg::*;

    logic signed [PF-1:0]     nx;
    logic signed [PF-1:0]     ny;
    logic signed [PF-1:0]     nz;
    logic signed [PF-1:0]     w;

    logic signed [PROD_W-1:0] px_reg, px_next;
    logic signed [PROD_W-1:0] py_reg, py_next;
    logic signed [PROD_W-1:0] pz_reg, pz_next;
    logic signed [DIFF_W-1:0] ofs_reg, ofs_next;
    logic signed [SUM_W-1:0]  sum;
    logic                     over_reg, over_next;

    assign nx = $signed(plane[PF-1:0]);
    assign ny = $signed(plane[2*PF-1:PF]);
    assign nz = $signed(plane[3*PF-1:2*PF]);
    assign w  = $signed(plane[4*PF-1:3*PF]);

    // Stage 1: three exact products and the offset minus radius
    always_comb
    begin
        px_next  = PROD_W'(nx) * PROD_W'(sphere.cx);
        py_next  = PROD_W'(ny) * PROD_W'(sphere.cy);
        pz_next  = PROD_W'(nz) * PROD_W'(sphere.cz);
        ofs_next = DIFF_W'(w) - DIFF_W'($signed({1'b0, sphere.r}));
    end

    // Stage 2: n.c + (w - r) * 2^F > 0 means the sphere is fully outside
    always_comb
    begin
        sum = SUM_W'(px_reg) + SUM_W'(py_reg) + SUM_W'(pz_reg)
            + (SUM_W'(ofs_reg) <<< NORMAL_FRACTION_BITS);
        over_next = !sum[SUM_W-1] && (sum != '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_en)
        begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            pz_reg  <= pz_next;
            ofs_reg <= ofs_next;
        end
        if (ctl.s2_en)
        begin
            over_reg <= over_next;
        end
    end

    assign over = over_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sfc_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module sfc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic a_visible,
    input wire logic b_visible
);
    logic [1:0] cnt_reg, cnt_next;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // Track transactions taken but not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_acc && !out_acc)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    `SFC_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid, "out_valid high during reset")
    `SFC_ASSERT(a_hold_result, out_valid && out_stall |=> out_valid && $stable(a_visible) && $stable(b_visible), "stalled result changed")
    `SFC_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled while output can drain")
    `SFC_ASSERT(a_no_phantom, out_valid |-> cnt_reg != 2'd0, "result without a pending transaction")
    `SFC_ASSERT(a_depth, cnt_reg == 2'd3 |-> !in_acc || out_acc, "more than three transactions in flight")

endmodule

bind sphere_frustum_cull_unit sfc_checker u_sfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .a_visible (a_visible),
    .b_visible (b_visible)
);

`default_nettype wire
